>>> rtl/core/waypoint_follow_controller_unit_defines.svh
// ----------------------------------------------------------------------------
// Waypoint follow controller assertion macros
// Concurrent check wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOW_CONTROLLER_UNIT_DEFINES_SVH
`define WAYPOINT_FOLLOW_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define WFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WFC_ASSERT(label, prop, msg)
`define WFC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/wfc_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller package
// Shared widths, codes, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wfc_pkg;

    localparam int POS_W  = 24;
    localparam int HEAD_W = 16;
    localparam int DIFF_W = 25;
    localparam int CX_W   = 36;
    localparam int CZ_W   = 34;
    localparam int MAG_W  = 35;
    localparam int DIST_W = 26;
    localparam int MA_W   = 36;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SCL_W  = PROD_W - 8;
    localparam int ITER_W = 5;
    localparam int RAD_W  = 23;
    localparam int GAIN_W = 12;
    localparam int LIN_W  = 23;
    localparam int ANG_W  = 20;
    localparam int REM_W  = 5;
    localparam int ST_W   = 3;

    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [CZ_W-1:0] Z_QUARTER = 34'sd1073741824;
    localparam logic signed [SCL_W-1:0] LIN_MAX = 45'sd8388607;
    localparam logic signed [SCL_W-1:0] ANG_MAX = 45'sd524287;
    localparam logic signed [SCL_W-1:0] ANG_MIN = -45'sd524288;

    localparam logic [RAD_W-1:0]  RADIUS_RST = 23'd256;
    localparam logic [GAIN_W-1:0] GLIN_RST   = 12'd256;
    localparam logic [GAIN_W-1:0] GANG_RST   = 12'd1280;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_GLIN   = 2'd1,
        REG_GANG   = 2'd2
    } t_reg_idx;

    typedef enum logic [ST_W-1:0] {
        ST_APPROACH = 3'd0,
        ST_REACHED  = 3'd1,
        ST_DONE     = 3'd2,
        ST_STORED   = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_POSE   = 1'b1
    } t_opcode;

    typedef struct packed {
        logic push;
        logic pop;
    } t_plan_cmd;

    // atan(2^-i) with 2^31 = pi
    function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/wfc_plan.sv
// ----------------------------------------------------------------------------
// Waypoint plan queue
// Circular buffer of waypoints with registered read at the head entry.
// ----------------------------------------------------------------------------
module wfc_plan #(
    parameter int PLAN_DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wfc_pkg::t_plan_cmd                    i_cmd,
    input  logic signed [wfc_pkg::POS_W-1:0]      i_wr_x,
    input  logic signed [wfc_pkg::POS_W-1:0]      i_wr_y,
    output logic signed [wfc_pkg::POS_W-1:0]      o_rd_x,
    output logic signed [wfc_pkg::POS_W-1:0]      o_rd_y,
    output logic [$clog2(PLAN_DEPTH+1)-1:0]       o_count,
    output logic                                  o_full
);

    localparam int AW = $clog2(PLAN_DEPTH);
    localparam int CW = $clog2(PLAN_DEPTH + 1);
    localparam int EW = 2 * wfc_pkg::POS_W;

    logic [EW-1:0] r_mem [PLAN_DEPTH];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(PLAN_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (i_cmd.pop) begin
                r_head <= ptr_inc(r_head);
            end
            if (i_cmd.push && !i_cmd.pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop && !i_cmd.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= {i_wr_y, i_wr_x};
        end
        r_rd <= r_mem[r_head];
    end

    assign o_rd_x  = r_rd[wfc_pkg::POS_W-1:0];
    assign o_rd_y  = r_rd[EW-1:wfc_pkg::POS_W];
    assign o_count = r_count;
    assign o_full  = (r_count == CW'(PLAN_DEPTH));

endmodule

>>> rtl/core/wfc_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC vectoring unit
// One micro-rotation per cycle; gives raw magnitude and angle of (dx, dy).
// ----------------------------------------------------------------------------
module wfc_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [wfc_pkg::DIFF_W-1:0]     i_dx,
    input  logic signed [wfc_pkg::DIFF_W-1:0]     i_dy,
    output logic                                  o_done,
    output logic [wfc_pkg::MAG_W-1:0]             o_mag,
    output logic signed [wfc_pkg::CZ_W-1:0]       o_ang
);

    localparam int CX_W = wfc_pkg::CX_W;
    localparam int CZ_W = wfc_pkg::CZ_W;
    localparam int EXT  = CX_W - wfc_pkg::DIFF_W - 8;

    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [CZ_W-1:0] r_z;
    logic [wfc_pkg::ITER_W-1:0] r_iter;
    logic r_busy, r_done;

    logic signed [CX_W-1:0] w_x0, w_y0, w_xp, w_yp, w_xs, w_ys;
    logic signed [CZ_W-1:0] w_zp, w_atan;

    assign w_x0 = {{EXT{i_dx[wfc_pkg::DIFF_W-1]}}, i_dx, 8'd0};
    assign w_y0 = {{EXT{i_dy[wfc_pkg::DIFF_W-1]}}, i_dy, 8'd0};

    always_comb begin
        w_xp = w_x0;
        w_yp = w_y0;
        w_zp = '0;
        if (w_x0 < 0) begin
            if (w_y0 > 0) begin
                w_xp = w_y0;
                w_yp = -w_x0;
                w_zp = wfc_pkg::Z_QUARTER;
            end else begin
                w_xp = -w_y0;
                w_yp = w_x0;
                w_zp = -wfc_pkg::Z_QUARTER;
            end
        end
    end

    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = $signed({{(CZ_W-30){1'b0}}, wfc_pkg::atan_lut(r_iter)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_iter == wfc_pkg::ITER_W'(STAGES - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= w_xp;
            r_y    <= w_yp;
            r_z    <= w_zp;
            r_iter <= '0;
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
            r_iter <= r_iter + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_x[CX_W-1] ? '0 : r_x[wfc_pkg::MAG_W-1:0];
    assign o_ang  = r_z;

endmodule

>>> rtl/core/waypoint_follow_controller_unit.sv
// Append, and pose with an empty plan: the accepted item goes straight to S_OUT, which registers the result.
// Pose: S_READ, S_START, S_CORDIC, S_MDIST, S_DIST, S_CHECK, S_MLIN, S_SLIN, S_SANG, S_OUT; a second
// vectoring pass runs when the head waypoint is reached and the next one is targeted.
// One transaction at a time; the CORDIC iteration and the shared multiplier set the pace.
// Synchronous active-low reset clears the plan, the sequencer and restores registers.
// ----------------------------------------------------------------------------
// Waypoint follow controller
// Plan queue, CORDIC distance/bearing and proportional speed commands.
// ----------------------------------------------------------------------------
`include "waypoint_follow_controller_unit_defines.svh"

module waypoint_follow_controller_unit #(
    parameter int PLAN_DEPTH    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pos_x[23:0], pos_y[47:24], heading[63:48]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // lin_speed[22:0], ang_speed[42:23], remaining[47:43]
    output logic [2:0]  m_tuser,   // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(PLAN_DEPTH + 1);
    localparam int POS_W = wfc_pkg::POS_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_READ   = 11'b00000000010,
        S_START  = 11'b00000000100,
        S_CORDIC = 11'b00000001000,
        S_MDIST  = 11'b00000010000,
        S_DIST   = 11'b00000100000,
        S_CHECK  = 11'b00001000000,
        S_MLIN   = 11'b00010000000,
        S_SLIN   = 11'b00100000000,
        S_SANG   = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [wfc_pkg::RAD_W-1:0]  r_radius;
    logic [wfc_pkg::GAIN_W-1:0] r_glin, r_gang;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= wfc_pkg::RADIUS_RST;
            r_glin   <= wfc_pkg::GLIN_RST;
            r_gang   <= wfc_pkg::GANG_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                wfc_pkg::REG_RADIUS: r_radius <= pwdata[wfc_pkg::RAD_W-1:0];
                wfc_pkg::REG_GLIN:   r_glin   <= pwdata[wfc_pkg::GAIN_W-1:0];
                wfc_pkg::REG_GANG:   r_gang   <= pwdata[wfc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wfc_pkg::REG_RADIUS: prdata = 32'(r_radius);
            wfc_pkg::REG_GLIN:   prdata = 32'(r_glin);
            wfc_pkg::REG_GANG:   prdata = 32'(r_gang);
            default:             prdata = '0;
        endcase
    end

    // input transaction
    logic w_in_acc;
    logic signed [POS_W-1:0] w_in_x, w_in_y;
    logic signed [wfc_pkg::HEAD_W-1:0] r_hd;
    logic signed [POS_W-1:0] r_px, r_py;

    assign s_tready = (r_state == S_IDLE);
    assign w_in_acc = s_tvalid && s_tready;
    assign w_in_x   = s_tdata[POS_W-1:0];
    assign w_in_y   = s_tdata[2*POS_W-1:POS_W];

    // plan queue
    wfc_pkg::t_plan_cmd w_cmd;
    logic signed [POS_W-1:0] w_rd_x, w_rd_y;
    logic [CW-1:0] w_count;
    logic w_full;
    logic w_reach;
    logic r_popped;

    assign w_cmd.push = w_in_acc && (s_tuser[0] == wfc_pkg::OP_APPEND) && !w_full;
    assign w_cmd.pop  = (r_state == S_CHECK) && w_reach && !r_popped;

    wfc_plan #(
        .PLAN_DEPTH (PLAN_DEPTH)
    ) u_plan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_wr_x  (w_in_x),
        .i_wr_y  (w_in_y),
        .o_rd_x  (w_rd_x),
        .o_rd_y  (w_rd_y),
        .o_count (w_count),
        .o_full  (w_full)
    );

    // CORDIC
    logic w_cstart, w_cdone;
    logic signed [wfc_pkg::DIFF_W-1:0] w_dx, w_dy;
    logic [wfc_pkg::MAG_W-1:0] w_mag;
    logic signed [wfc_pkg::CZ_W-1:0] w_z, w_zr;
    logic signed [wfc_pkg::HEAD_W-1:0] w_err, r_err;

    assign w_cstart = (r_state == S_START);
    assign w_dx = {w_rd_x[POS_W-1], w_rd_x} - {r_px[POS_W-1], r_px};
    assign w_dy = {w_rd_y[POS_W-1], w_rd_y} - {r_py[POS_W-1], r_py};

    wfc_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .o_done  (w_cdone),
        .o_mag   (w_mag),
        .o_ang   (w_z)
    );

    assign w_zr  = w_z + 34'sd32768;
    assign w_err = w_zr[wfc_pkg::HEAD_W+15:16] - r_hd;

    // shared multiplier
    logic signed [wfc_pkg::MA_W-1:0]   w_ma;
    logic signed [wfc_pkg::MB_W-1:0]   w_mb;
    logic signed [wfc_pkg::PROD_W-1:0] r_prod, w_dist_rnd, w_rnd;
    logic signed [wfc_pkg::SCL_W-1:0]  w_scl;
    logic [wfc_pkg::DIST_W-1:0] r_dist;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_MDIST) begin
            w_ma = $signed({1'b0, w_mag});
            w_mb = $signed({1'b0, wfc_pkg::INV_GAIN_Q16});
        end else if (r_state == S_MLIN) begin
            w_ma = $signed({{(wfc_pkg::MA_W-wfc_pkg::DIST_W){1'b0}}, r_dist});
            w_mb = $signed({{(wfc_pkg::MB_W-wfc_pkg::GAIN_W){1'b0}}, r_glin});
        end else if (r_state == S_SLIN) begin
            w_ma = {{(wfc_pkg::MA_W-wfc_pkg::HEAD_W){r_err[wfc_pkg::HEAD_W-1]}}, r_err};
            w_mb = $signed({{(wfc_pkg::MB_W-wfc_pkg::GAIN_W){1'b0}}, r_gang});
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    assign w_dist_rnd = r_prod + 53'sd8388608;
    assign w_rnd      = r_prod + 53'sd128;
    assign w_scl      = w_rnd[wfc_pkg::PROD_W-1:8];
    assign w_reach    = ({{(wfc_pkg::DIST_W-wfc_pkg::RAD_W){1'b0}}, r_radius} >= r_dist);

    // result
    wfc_pkg::t_status r_st;
    logic [wfc_pkg::LIN_W-1:0] r_lin;
    logic [wfc_pkg::ANG_W-1:0] r_ang;
    logic r_m_valid;
    logic [47:0] r_m_data;
    logic [2:0]  r_m_user;
    logic [CW+wfc_pkg::REM_W-1:0] w_cnt_ext;
    logic w_out_free;

    assign w_cnt_ext  = {wfc_pkg::REM_W'(0), w_count};
    assign w_out_free = !r_m_valid || m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_tuser[0] == wfc_pkg::OP_APPEND || w_count == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:   n_state = S_START;
            S_START:  n_state = S_CORDIC;
            S_CORDIC: if (w_cdone) n_state = S_MDIST;
            S_MDIST:  n_state = S_DIST;
            S_DIST:   n_state = S_CHECK;
            S_CHECK: begin
                if (w_reach && !r_popped) begin
                    n_state = (w_count == CW'(1)) ? S_OUT : S_READ;
                end else begin
                    n_state = S_MLIN;
                end
            end
            S_MLIN:   n_state = S_SLIN;
            S_SLIN:   n_state = S_SANG;
            S_SANG:   n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px     <= w_in_x;
            r_py     <= w_in_y;
            r_hd     <= s_tdata[63:2*POS_W];
            r_popped <= 1'b0;
            r_lin    <= '0;
            r_ang    <= '0;
            if (s_tuser[0] == wfc_pkg::OP_APPEND) begin
                r_st <= w_full ? wfc_pkg::ST_FULL : wfc_pkg::ST_STORED;
            end else if (w_count == '0) begin
                r_st <= wfc_pkg::ST_DONE;
            end else begin
                r_st <= wfc_pkg::ST_APPROACH;
            end
        end
        if (r_state == S_CORDIC && w_cdone) begin
            r_err <= w_err;
        end
        if (r_state == S_DIST) begin
            r_dist <= w_dist_rnd[wfc_pkg::DIST_W+23:24];
        end
        if (r_state == S_CHECK && w_reach && !r_popped) begin
            r_popped <= 1'b1;
            r_st     <= (w_count == CW'(1)) ? wfc_pkg::ST_DONE : wfc_pkg::ST_REACHED;
        end
        if (r_state == S_SLIN) begin
            r_lin <= (w_scl > wfc_pkg::LIN_MAX) ? wfc_pkg::LIN_MAX[wfc_pkg::LIN_W-1:0]
                                                : w_scl[wfc_pkg::LIN_W-1:0];
        end
        if (r_state == S_SANG) begin
            priority if (w_scl > wfc_pkg::ANG_MAX) begin
                r_ang <= wfc_pkg::ANG_MAX[wfc_pkg::ANG_W-1:0];
            end else if (w_scl < wfc_pkg::ANG_MIN) begin
                r_ang <= wfc_pkg::ANG_MIN[wfc_pkg::ANG_W-1:0];
            end else begin
                r_ang <= w_scl[wfc_pkg::ANG_W-1:0];
            end
        end
        if (r_state == S_OUT && w_out_free) begin
            r_m_data <= {w_cnt_ext[wfc_pkg::REM_W-1:0], r_ang, r_lin};
            r_m_user <= r_st;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

    `WFC_ASSERT(a_count_bound, w_count <= CW'(PLAN_DEPTH), "plan count above depth")
    `WFC_ASSERT(a_pop_nonempty, w_cmd.pop |-> (w_count != '0), "pop from empty plan")
    `WFC_ASSERT_NEXT(a_pop_dec, w_cmd.pop, w_count == CW'($past(w_count) - 1'b1), "pop lost")
    `WFC_ASSERT(a_done_zero, (m_tvalid && m_tuser == wfc_pkg::ST_DONE) |-> (m_tdata == '0), "done carries nonzero data")

endmodule

>>> tb/waypoint_follow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint follow controller checker
// Watches the pose/waypoint stream, the command stream and the register
// port, keeps its own copy of the plan queue and registers, predicts each
// speed command and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module waypoint_follow_checker
    import wfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // pos_x[23:0], pos_y[47:24], heading[63:48]
    input  logic [0:0]  i_s_tuser,   // opcode[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // lin_speed[22:0], ang_speed[42:23], remaining[47:43]
    input  logic [2:0]  i_m_tuser,   // status[2:0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int     PLAN_DEPTH    = 16;
    localparam int     CORDIC_STAGES = 16;
    localparam longint HALF_PI_Q31   = 64'sd1073741824;
    localparam longint INV_K_Q16     = 64'sd39797;
    localparam longint LIN_SAT       = 64'sd8388607;
    localparam longint ANG_SAT_HI    = 64'sd524287;
    localparam longint ANG_SAT_LO    = -64'sd524288;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct packed {
        t_status            status;
        logic [22:0]        lin;
        logic signed [19:0] ang;
        logic [4:0]         rem;
    } steer_cmd_t;

    // atan(2^-i), pi = 2^31
    longint arc_tan_q31 [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic signed [23:0] wp_x [PLAN_DEPTH];
    logic signed [23:0] wp_y [PLAN_DEPTH];
    int unsigned        plan_head  = 0;
    int unsigned        plan_count = 0;
    logic [22:0]        arrive_radius = RADIUS_RST;
    logic [11:0]        k_lin = GLIN_RST;
    logic [11:0]        k_ang = GANG_RST;

    steer_cmd_t expected_cmds [$];
    int         fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void range_bearing(input longint dx, input longint dy,
                                          output longint rng, output longint bear);
        longint x, y, z, t, xs, ys;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (x < 0) begin
            if (y > 0) begin
                t = x; x = y; y = -t; z = HALF_PI_Q31;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_Q31;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + arc_tan_q31[i];
            end else begin
                x = x - ys; y = y + xs; z = z - arc_tan_q31[i];
            end
        end
        if (x < 0) x = 0;
        rng  = (x * INV_K_Q16 + 64'sd8388608) >>> 24;
        bear = (z + 64'sd32768) >>> 16;
    endfunction

    function automatic steer_cmd_t predict_command(input t_opcode op,
                                                   input logic signed [23:0] px,
                                                   input logic signed [23:0] py,
                                                   input logic signed [15:0] hd);
        steer_cmd_t  c;
        longint      rng, bear, err, lin, ang;
        int unsigned slot;
        c.status = ST_APPROACH;
        c.lin    = '0;
        c.ang    = '0;
        c.rem    = '0;
        if (op == OP_APPEND) begin
            if (plan_count >= PLAN_DEPTH) begin
                c.status = ST_FULL;
            end else begin
                slot = (plan_head + plan_count) % PLAN_DEPTH;
                wp_x[slot] = px;
                wp_y[slot] = py;
                plan_count++;
                c.status = ST_STORED;
            end
            c.rem = plan_count[4:0];
            return c;
        end
        if (plan_count == 0) begin
            c.status = ST_DONE;
            return c;
        end
        range_bearing(longint'(wp_x[plan_head]) - longint'(px),
                      longint'(wp_y[plan_head]) - longint'(py), rng, bear);
        if (longint'(arrive_radius) >= rng) begin
            plan_head = (plan_head + 1) % PLAN_DEPTH;
            plan_count--;
            if (plan_count == 0) begin
                c.status = ST_DONE;
                return c;
            end
            c.status = ST_REACHED;
            range_bearing(longint'(wp_x[plan_head]) - longint'(px),
                          longint'(wp_y[plan_head]) - longint'(py), rng, bear);
        end
        err = longint'((bear - longint'(hd) + 32768) & 64'hFFFF) - 32768;
        lin = (longint'(k_lin) * rng + 128) >>> 8;
        ang = (longint'(k_ang) * err + 128) >>> 8;
        if (lin > LIN_SAT) lin = LIN_SAT;
        if (lin < 0) lin = 0;
        if (ang > ANG_SAT_HI) ang = ANG_SAT_HI;
        if (ang < ANG_SAT_LO) ang = ANG_SAT_LO;
        c.lin = lin[22:0];
        c.ang = ang[19:0];
        c.rem = plan_count[4:0];
        return c;
    endfunction

    always @(posedge i_clk) begin : monitor
        steer_cmd_t want, got;
        if (!i_rst_n) begin
            plan_head     = 0;
            plan_count    = 0;
            arrive_radius = RADIUS_RST;
            k_lin         = GLIN_RST;
            k_ang         = GANG_RST;
            expected_cmds.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_RADIUS: arrive_radius = i_pwdata[22:0];
                    REG_GLIN:   k_lin = i_pwdata[11:0];
                    REG_GANG:   k_ang = i_pwdata[11:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.lin    = i_m_tdata[22:0];
                got.ang    = i_m_tdata[42:23];
                got.rem    = i_m_tdata[47:43];
                if (expected_cmds.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: command with nothing pending: status %0d lin %0d",
                                 $realtime, got.status, got.lin);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.status !== want.status || got.lin !== want.lin ||
                        got.ang !== want.ang || got.rem !== want.rem) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display({"%0t: command mismatch (expected/actual): status %0d/%0d",
                                      " lin %0d/%0d ang %0d/%0d remaining %0d/%0d"},
                                     $realtime, want.status, got.status, want.lin, got.lin,
                                     want.ang, got.ang, want.rem, got.rem);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_cmds.push_back(predict_command(t_opcode'(i_s_tuser[0]),
                                                        i_s_tdata[23:0], i_s_tdata[47:24],
                                                        i_s_tdata[63:48]));
        end
        o_pending    <= expected_cmds.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb_waypoint_follow_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint follow controller testbench
// Drives waypoint and pose transactions plus register writes into the
// controller: a directed opening, then four randomized phases with different
// sender/receiver idling, gains and arrival radius. Poses are mostly aimed
// at the current head waypoint, either inside or clearly outside the radius.
// ----------------------------------------------------------------------------
module tb_waypoint_follow_controller_unit;
    import wfc_pkg::*;

    localparam int         PLAN_DEPTH    = 16;
    localparam int         DRAIN_CYCLES  = 60;
    localparam int         QUIET_LIMIT   = 5000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         PHASE_ITEMS   = 160;
    localparam int         POS_MAX       = 8388607;
    localparam int         POS_MIN       = -8388608;
    localparam logic [3:0] ADDR_UNMAPPED = 4'd12;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // pos_x[23:0], pos_y[47:24], heading[63:48]
    logic [0:0]  s_tuser  = '0;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // lin_speed[22:0], ang_speed[42:23], remaining[47:43]
    logic [2:0]  m_tuser;         // status[2:0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int cmds_pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    int cur_radius   = 256;
    int quiet_cycles = 0;

    logic signed [23:0] route_x_q [$];
    logic signed [23:0] route_y_q [$];

    always #5 i_clk = ~i_clk;

    waypoint_follow_controller_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    waypoint_follow_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (cmds_pending)
    );

    // watchdog: cycles without any accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // valid stays high after an accept unless an idle cycle follows
    task automatic send_item(input t_opcode op, input logic signed [23:0] x,
                             input logic signed [23:0] y, input logic signed [15:0] hd);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hd, y, x};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_append(input logic signed [23:0] x, input logic signed [23:0] y);
        if (route_x_q.size() < PLAN_DEPTH) begin
            route_x_q.push_back(x);
            route_y_q.push_back(y);
        end
        send_item(OP_APPEND, x, y, 16'($urandom));
    endtask

    task automatic send_pose(input logic signed [23:0] x, input logic signed [23:0] y,
                             input logic signed [15:0] hd, input bit pops);
        if (pops && route_x_q.size() > 0) begin
            void'(route_x_q.pop_front());
            void'(route_y_q.pop_front());
        end
        send_item(OP_POSE, x, y, hd);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (cmds_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] clamp_pos(input longint v);
        if (v > POS_MAX) return 24'(POS_MAX);
        if (v < POS_MIN) return 24'(POS_MIN);
        return 24'(v);
    endfunction

    // step away from a waypoint toward the middle of the field, never out of range
    function automatic logic signed [23:0] toward_center(input logic signed [23:0] w,
                                                         input int m);
        if (w >= 0) return 24'(longint'(w) - m);
        return 24'(longint'(w) + m);
    endfunction

    task automatic random_step(input int n);
        bit                 fill_mode;
        int                 pick, bound, lo, far_mag, near_mag;
        logic signed [23:0] wx, wy, px, py;
        fill_mode = ((n / 40) % 2) == 0;
        pick = $urandom_range(99);
        wx = 24'($urandom);
        wy = 24'($urandom);
        if (pick < 6) begin
            if ($urandom_range(1)) send_append(wx, wy);
            else send_pose(wx, wy, 16'($urandom), 1'b0);
        end else if (pick < (fill_mode ? 50 : 20) &&
                     (route_x_q.size() < PLAN_DEPTH || $urandom_range(3) == 0)) begin
            send_append(wx, wy);
        end else if (route_x_q.size() == 0) begin
            send_pose(wx, wy, 16'($urandom), 1'b0);
        end else if ($urandom_range(99) < (fill_mode ? 30 : 60)) begin
            bound = cur_radius / 2;
            px = clamp_pos(longint'(route_x_q[0]) + longint'($urandom_range(2 * bound))
                           - bound);
            py = clamp_pos(longint'(route_y_q[0]) + longint'($urandom_range(2 * bound))
                           - bound);
            send_pose(px, py, 16'($urandom), 1'b1);
        end else begin
            lo = 2 * cur_radius + 64;
            if (lo > POS_MAX) lo = POS_MAX;
            if ($urandom_range(1))
                far_mag = $urandom_range(POS_MAX, lo);
            else
                far_mag = $urandom_range((lo > POS_MAX / 2 - 4096) ? POS_MAX : 2 * lo + 4096,
                                         lo);
            near_mag = $urandom_range(far_mag);
            if ($urandom_range(1)) begin
                px = toward_center(route_x_q[0], far_mag);
                py = toward_center(route_y_q[0], near_mag);
            end else begin
                px = toward_center(route_x_q[0], near_mag);
                py = toward_center(route_y_q[0], far_mag);
            end
            send_pose(px, py, 16'($urandom), 1'b0);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [22:0] radius,
                             input logic [11:0] g_lin, input logic [11:0] g_ang,
                             input bit with_hold);
        settle();
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        apb_write({REG_RADIUS, 2'b00}, 32'(radius));
        apb_write({REG_GLIN, 2'b00}, 32'(g_lin));
        apb_write({REG_GANG, 2'b00}, 32'(g_ang));
        apb_write(ADDR_UNMAPPED, $urandom);
        cur_radius = radius;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (with_hold && n == PHASE_ITEMS / 3) hold_req = 1'b1;
            random_step(n);
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset gains and radius
        send_pose(24'sd8388607 + 24'sd1, 24'sd8388607, -16'sd32768, 1'b0);    // empty plan
        send_append(24'sd8388607, -24'sd8388607 - 24'sd1);
        send_append(-24'sd8388607 - 24'sd1, 24'sd8388607);
        send_append(24'sd0, 24'sd0);
        send_pose(-24'sd8388607 - 24'sd1, 24'sd8388607, 16'sd32767, 1'b0);    // far, saturates
        send_pose(24'sd8388607, -24'sd8388607 - 24'sd1, 16'sd0, 1'b1);        // coincident
        send_pose(-24'sd8388607 - 24'sd1, 24'sd8388607, 16'sd16384, 1'b1);
        send_pose(24'sd100, -24'sd100, -16'sd32768, 1'b1);                    // last one reached
        repeat (PLAN_DEPTH) send_append(24'($urandom), 24'($urandom));
        send_append(24'($urandom), 24'($urandom));                            // plan full

        run_phase(0, 0, 23'd0, 12'd4095, 12'd4095, 1'b1);
        run_phase(71, 0, 23'($urandom_range(4096, 1)), 12'd0, 12'd0, 1'b0);
        run_phase(0, 71, 23'd8388607, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  1'b0);
        run_phase(26, 26, 23'($urandom_range(65536, 256)), 12'($urandom_range(4095)),
                  12'($urandom_range(4095)), 1'b0);
        settle();

        if (fail_count == 0 && cmds_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
